// ===== sv/ipv4p_pkg.sv =====
// Shared types, constants and the character classifier for the IPv4 line parser.
package ipv4p_pkg;

  // Longest field, in characters, including the terminating one
  localparam int MaxFieldChars = 32;
  localparam int DigitCntW     = $clog2(MaxFieldChars);

  // Depth of the queue between the classifier and the parser
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // Character codes
  localparam logic [7:0] ChNul   = 8'd0;
  localparam logic [7:0] ChTab   = 8'd9;
  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChDot   = 8'd46;
  localparam logic [7:0] ChZero  = 8'd48;
  localparam logic [7:0] ChNine  = 8'd57;

  // Result status codes
  localparam logic [1:0] StValid   = 2'd0;
  localparam logic [1:0] StIgnore  = 2'd1;
  localparam logic [1:0] StInvalid = 2'd2;

  // Largest octet value
  localparam logic [11:0] OctetMax = 12'd255;

  typedef enum logic [1:0] {
    PhSkip,
    PhFields,
    PhDone
  } phase_e;

  // One classified character as it travels through the queue
  typedef struct packed {
    logic       is_digit;
    logic       is_space;
    logic       is_dot;
    logic       is_nul;
    logic [3:0] digit;
    logic       last;
  } char_class_t;

  // Sort a byte into the classes the parser cares about
  function automatic char_class_t classify(input logic [7:0] ch, input logic last);
    char_class_t c;
    logic [7:0]  diff;
    diff       = ch - ChZero;
    c.is_digit = (ch >= ChZero) && (ch <= ChNine);
    c.is_space = (ch == ChSpace) || ((ch >= ChTab) && (ch <= ChCr));
    c.is_dot   = (ch == ChDot);
    c.is_nul   = (ch == ChNul);
    c.digit    = diff[3:0];
    c.last     = last;
    return c;
  endfunction

endpackage

// ===== sv/ipv4p_front.sv =====
// Front end: accepts characters from the input queue port and classifies them.
module ipv4p_front (
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            ch_i,
  input  logic                  last_i,
  input  logic                  q_full_i,
  output logic                  q_wr_o,
  output ipv4p_pkg::char_class_t q_data_o
);
  import ipv4p_pkg::*;

  // Accept a transaction whenever the queue has room
  assign full     = q_full_i;
  assign q_wr_o   = push & ~q_full_i;
  assign q_data_o = classify(ch_i, last_i);

endmodule

// ===== sv/ipv4p_queue.sv =====
// Short queue of classified characters between the front end and the parser.
module ipv4p_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_i,
  input  ipv4p_pkg::char_class_t wr_data_i,
  output logic                   full_o,
  input  logic                   rd_i,
  output logic                   valid_o,
  output ipv4p_pkg::char_class_t rd_data_o
);
  import ipv4p_pkg::*;

  char_class_t           mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]  cnt_q, cnt_d;
  logic                  do_wr, do_rd;

  assign full_o    = (cnt_q == QueueCntW'(QueueDepth));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i & ~full_o;
  assign do_rd     = rd_i & valid_o;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + QueueCntW'(do_wr) - QueueCntW'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QueueCntW'(QueueDepth))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with unequal pointers");
`endif

endmodule

// ===== sv/ipv4p_back.sv =====
// Back end: runs the line parser over classified characters and holds the result.
module ipv4p_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  ipv4p_pkg::char_class_t q_data_i,
  output logic                   q_rd_o,
  output logic                   empty,
  input  logic                   pop,
  output logic [31:0]            address_o,
  output logic [1:0]             status_o
);
  import ipv4p_pkg::*;

  localparam logic [DigitCntW-1:0] DigitLimit = DigitCntW'(MaxFieldChars - 1);

  phase_e               phase_q, phase_d;
  logic [1:0]           field_idx_q, field_idx_d;
  logic [DigitCntW-1:0] digit_cnt_q, digit_cnt_d;
  logic [7:0]           field_val_q, field_val_d;
  logic [23:0]          octets_q, octets_d;

  logic                 res_valid_q;
  logic [31:0]          address_q;
  logic [1:0]           status_q;

  logic                 take;
  logic                 decide;
  logic [1:0]           dec_status;
  logic [31:0]          dec_addr;
  logic                 in_fields;
  logic [11:0]          next_val;
  char_class_t          c;

  assign c         = q_data_i;
  assign take      = q_valid_i & (~res_valid_q | pop);
  assign q_rd_o    = take;
  assign in_fields = (phase_q == PhFields) ||
                     ((phase_q == PhSkip) && !c.is_space && !c.is_nul);
  assign next_val  = {1'b0, field_val_q, 3'b000} + {3'b000, field_val_q, 1'b0} +
                     {8'h00, c.digit};

  // Decide whether this character closes the line and with which status
  always_comb begin
    decide     = 1'b0;
    dec_status = StInvalid;
    dec_addr   = '0;
    if (phase_q == PhSkip && c.is_space) begin
      decide     = c.last;
      dec_status = StIgnore;
    end else if (phase_q == PhSkip && c.is_nul) begin
      decide     = 1'b1;
      dec_status = StIgnore;
    end else if (in_fields) begin
      priority if (c.is_digit) begin
        decide = (digit_cnt_q >= DigitLimit) || (next_val > OctetMax) || c.last;
      end else if (field_idx_q != 2'd3) begin
        decide = !c.is_dot || (digit_cnt_q == '0) || c.last;
      end else begin
        decide = 1'b1;
        if ((c.is_nul || c.is_space) && digit_cnt_q != '0) begin
          dec_status = StValid;
          dec_addr   = {octets_q, field_val_q};
        end
      end
    end
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (take) begin
      if (decide) begin
        phase_d = c.last ? PhSkip : PhDone;
      end else if (phase_q == PhDone) begin
        phase_d = c.last ? PhSkip : PhDone;
      end else if (in_fields) begin
        phase_d = PhFields;
      end
    end
  end

  // Field accumulation; clear everything when a line starts over
  always_comb begin
    field_idx_d = field_idx_q;
    digit_cnt_d = digit_cnt_q;
    field_val_d = field_val_q;
    octets_d    = octets_q;
    if (take) begin
      if (phase_d == PhSkip) begin
        field_idx_d = '0;
        digit_cnt_d = '0;
        field_val_d = '0;
        octets_d    = '0;
      end else if (in_fields && !decide) begin
        if (c.is_digit) begin
          field_val_d = next_val[7:0];
          digit_cnt_d = digit_cnt_q + 1'b1;
        end else begin
          octets_d    = {octets_q[15:0], field_val_q};
          field_idx_d = field_idx_q + 1'b1;
          digit_cnt_d = '0;
          field_val_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhSkip;
      field_idx_q <= '0;
      digit_cnt_q <= '0;
      field_val_q <= '0;
      octets_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      field_idx_q <= field_idx_d;
      digit_cnt_q <= digit_cnt_d;
      field_val_q <= field_val_d;
      octets_q    <= octets_d;
      if (take && decide) begin
        res_valid_q <= 1'b1;
      end else if (pop) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (take && decide) begin
      address_q <= dec_addr;
      status_q  <= dec_status;
    end
  end

  assign empty     = ~res_valid_q;
  assign address_o = address_q;
  assign status_o  = status_q;

`ifndef SYNTHESIS
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (status_q == StValid || status_q == StIgnore || status_q == StInvalid))
    else $error("result with unknown status");

  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && status_q != StValid) |-> (address_q == '0))
    else $error("nonzero address on a non-valid result");

  a_skip_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhSkip) |->
      (field_idx_q == '0 && digit_cnt_q == '0 && field_val_q == '0 && octets_q == '0))
    else $error("field state not cleared while skipping");

  a_empty_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (digit_cnt_q == '0) |-> (field_val_q == '0))
    else $error("field value without digits");
`endif

endmodule

// ===== sv/ipv4_text_line_parser.sv =====
// Sustained rate is one character per clock: the classifier writes a two-entry queue and the
// parser consumes one entry per cycle, so the queue fills (full high) only while a finished
// result waits unpopped in the output register. A result is registered when the parser takes its
// deciding character from the queue; a line gives exactly one result (valid, blank, or invalid).
module ipv4_text_line_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  ch_i,
  input  logic        last_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] address_o,
  output logic [1:0]  status_o
);
  import ipv4p_pkg::*;

  logic        q_wr, q_full, q_rd, q_valid;
  char_class_t q_wr_data, q_rd_data;

  // Classify incoming characters
  ipv4p_front u_front (
    .push     (push),
    .full     (full),
    .ch_i     (ch_i),
    .last_i   (last_i),
    .q_full_i (q_full),
    .q_wr_o   (q_wr),
    .q_data_o (q_wr_data)
  );

  // Decouple front and back
  ipv4p_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (q_wr_data),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .valid_o   (q_valid),
    .rd_data_o (q_rd_data)
  );

  // Parse and hold results
  ipv4p_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_rd_data),
    .q_rd_o    (q_rd),
    .empty     (empty),
    .pop       (pop),
    .address_o (address_o),
    .status_o  (status_o)
  );

endmodule

// ===== sim/ipv4_line_checker.sv =====
// Checker for the IPv4 line parser: predicts each line's result and compares it with the output.
`timescale 1ns / 1ps

module ipv4_line_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [7:0]  ch_i,
  input  logic        last_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [31:0] address_i,
  input  logic [1:0]  status_i,
  output int          err_cnt_o,
  output int          pending_o
);
  import ipv4p_pkg::*;

  typedef struct packed {
    logic [31:0] address;
    logic [1:0]  status;
  } line_result_t;

  // Parser state as the predictor tracks it
  phase_e       ph;
  int           fld_idx;
  int           ndigits;
  int           fld_val;
  logic [23:0]  octets;
  line_result_t line_results_q[$];
  int           result_idx;

  task automatic clear_line();
    ph      = PhSkip;
    fld_idx = 0;
    ndigits = 0;
    fld_val = 0;
    octets  = '0;
  endtask

  // Queue the line's result and either start over or wait for the end of the buffer
  task automatic decide(input logic [1:0] st, input logic [31:0] addr, input logic lst);
    line_result_t r;
    r.status  = st;
    r.address = (st == StValid) ? addr : '0;
    line_results_q.push_back(r);
    if (lst) clear_line();
    else ph = PhDone;
  endtask

  // Advance the predicted parser by one character
  task automatic parse_char(input logic [7:0] c, input logic lst);
    logic is_sp;
    logic is_dg;
    is_sp = (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
    is_dg = (c >= ChZero) && (c <= ChNine);
    if (ph == PhSkip) begin
      if (is_sp) begin
        if (lst) decide(StIgnore, '0, lst);
        return;
      end
      if (c == ChNul) begin
        decide(StIgnore, '0, lst);
        return;
      end
      ph      = PhFields;
      fld_idx = 0;
      ndigits = 0;
      fld_val = 0;
      octets  = '0;
    end else if (ph != PhFields) begin
      if (lst) clear_line();
      return;
    end
    if (is_dg) begin
      if (ndigits >= MaxFieldChars - 1) begin
        decide(StInvalid, '0, lst);
        return;
      end
      fld_val = fld_val * 10 + int'(c - ChZero);
      ndigits++;
      if (fld_val > 255 || lst) decide(StInvalid, '0, lst);
      return;
    end
    if (fld_idx < 3) begin
      if (c != ChDot || ndigits == 0 || lst) begin
        decide(StInvalid, '0, lst);
        return;
      end
      octets  = {octets[15:0], fld_val[7:0]};
      fld_idx++;
      ndigits = 0;
      fld_val = 0;
      return;
    end
    if ((c == ChNul || is_sp) && ndigits != 0) decide(StValid, {octets, fld_val[7:0]}, lst);
    else decide(StInvalid, '0, lst);
  endtask

  // Compare popped results, then predict from accepted characters
  always @(posedge clk_i or negedge rst_ni) begin
    line_result_t exp_r;
    if (!rst_ni) begin
      clear_line();
      line_results_q.delete();
      err_cnt_o  <= 0;
      pending_o  <= 0;
      result_idx = 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (line_results_q.size() == 0) begin
          if (err_cnt_o < 10)
            $display("result %0d: unexpected, address %h status %0d",
                     result_idx, address_i, status_i);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          exp_r = line_results_q.pop_front();
          if (address_i !== exp_r.address || status_i !== exp_r.status) begin
            if (err_cnt_o < 10)
              $display("result %0d: expected address %h status %0d, got address %h status %0d",
                       result_idx, exp_r.address, exp_r.status, address_i, status_i);
            err_cnt_o <= err_cnt_o + 1;
          end
        end
        result_idx++;
      end
      if (push_i && !full_i) parse_char(ch_i, last_i);
      pending_o <= line_results_q.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Top of the IPv4 line parser testbench: clock, reset, line stimulus and final verdict.
`timescale 1ns / 1ps

module tb_top;
  import ipv4p_pkg::*;

  localparam int CycleLimit  = 100000;
  localparam int PhaseChars  = 150;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  ch_i;
  logic        last_i;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] address_o;
  logic [1:0]  status_o;
  int          err_cnt;
  int          pending;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic [7:0]  line_chars[$];

  ipv4_text_line_parser uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .ch_i     (ch_i),
    .last_i   (last_i),
    .empty    (empty),
    .pop      (pop),
    .address_o(address_o),
    .status_o (status_o)
  );

  ipv4_line_checker chk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .full_i   (full),
    .ch_i     (ch_i),
    .last_i   (last_i),
    .empty_i  (empty),
    .pop_i    (pop),
    .address_i(address_o),
    .status_i (status_o),
    .err_cnt_o(err_cnt),
    .pending_o(pending)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stall the result side at random
  always @(negedge clk_i) begin
    pop <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic logic [7:0] rand_space();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? ChSpace : ChTab + 8'(k);
  endfunction

  task automatic add_text(input string s);
    foreach (s[i]) line_chars.push_back(s[i]);
  endtask

  // Append a decimal field padded with leading zeros to at least the given width
  task automatic add_field(input int value, input int width);
    logic [7:0] digs[$];
    int v;
    v = value;
    do begin
      digs.push_front(ChZero + 8'(v % 10));
      v = v / 10;
    end while (v > 0);
    while (digs.size() < width) digs.push_front(ChZero);
    foreach (digs[i]) line_chars.push_back(digs[i]);
  endtask

  // Build a dotted address line; one field may be made too large or too long
  task automatic add_dotted(input int bad_field, input int bad_kind);
    int v;
    int w;
    repeat ($urandom_range(0, 2)) line_chars.push_back(rand_space());
    for (int f = 0; f < 4; f++) begin
      case ($urandom_range(0, 3))
        0: v = 0;
        1: v = 255;
        default: v = $urandom_range(0, 255);
      endcase
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 5) : 1;
      if (f == bad_field && bad_kind == 1) v = $urandom_range(256, 999);
      if (f == bad_field && bad_kind == 2) begin
        v = $urandom_range(0, 255);
        w = $urandom_range(MaxFieldChars - 3, MaxFieldChars + 2);
      end
      add_field(v, w);
      if (f < 3) line_chars.push_back(ChDot);
    end
    line_chars.push_back(($urandom_range(0, 1) == 0) ? ChNul : rand_space());
    repeat ($urandom_range(0, 3)) line_chars.push_back(8'($urandom_range(0, 255)));
  endtask

  // Pick one random line, mostly well formed
  task automatic build_random_line();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      add_dotted(-1, 0);
    end else if (kind < 70) begin
      add_dotted(-1, 0);
      line_chars[$urandom_range(0, line_chars.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (kind < 78) begin
      add_dotted(-1, 0);
      kind = $urandom_range(1, line_chars.size() - 1);
      while (line_chars.size() > kind) void'(line_chars.pop_back());
    end else if (kind < 84) begin
      repeat ($urandom_range(0, 4)) line_chars.push_back(rand_space());
      if ($urandom_range(0, 1) == 0) begin
        line_chars.push_back(ChNul);
        repeat ($urandom_range(0, 3)) line_chars.push_back(8'($urandom_range(0, 255)));
      end else if (line_chars.size() == 0) begin
        line_chars.push_back(rand_space());
      end
    end else if (kind < 90) begin
      add_dotted($urandom_range(0, 3), 1);
    end else if (kind < 95) begin
      add_dotted($urandom_range(0, 3), 2);
    end else begin
      repeat ($urandom_range(1, 10)) line_chars.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Hand one character to the parser, idling at random first
  task automatic send_char(input logic [7:0] c, input logic lst);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push   <= 1'b1;
    ch_i   <= c;
    last_i <= lst;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // Send the buffered line with the final character flagged, then clear it
  task automatic send_line(inout int sent);
    foreach (line_chars[i]) send_char(line_chars[i], i == line_chars.size() - 1);
    sent += line_chars.size();
    line_chars.delete();
  endtask

  initial begin
    int sent;
    rst_ni = 1'b0;
    push   = 1'b0;
    ch_i   = '0;
    last_i = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed lines: blank and NUL lines, large value, empty field, early end, extremes
    sent = 0;
    line_chars.push_back(ChNul);
    send_line(sent);
    line_chars.push_back(ChCr);
    send_line(sent);
    add_text("256x");
    send_line(sent);
    add_text("1..2");
    send_line(sent);
    add_text("9.");
    send_line(sent);
    add_text("7");
    send_line(sent);
    add_text("255.0.0.255");
    line_chars.push_back(ChNul);
    send_line(sent);

    // Random lines under each idling pattern
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      sent = 0;
      while (sent < PhaseChars) begin
        build_random_line();
        send_line(sent);
      end
      // After the second pattern, hold off until every outstanding result has drained
      if (p == 1) begin
        @(negedge clk_i);
        push <= 1'b0;
        wait (pending == 0);
      end
    end

    @(negedge clk_i);
    push <= 1'b0;
    wait (pending == 0);
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
